@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh - assertion shorthands for the colour converter
// Both macros check on the rising clock edge and stay quiet while reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define HSV_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define HSV_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/hsv2rgb_pkg.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_pkg - shared types and constants of the HSV to RGB converter
// Field widths, hue sector codes, the scaling constants and the stage enables.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

    // Field widths
    localparam int unsigned HUE_W    = 9;
    localparam int unsigned PCT_W    = 7;
    localparam int unsigned CH_W     = 8;
    localparam int unsigned OFF_W    = 6;   // offset inside a sector, 0..59
    localparam int unsigned ARG_W    = 13;  // 6000 - s*x terms, up to 6000
    localparam int unsigned PROD_W   = 20;  // v * arg, up to 600000
    localparam int unsigned MUL17_W  = 24;  // 17 * v * arg
    localparam int unsigned SCALED_W = 18;  // 17 * v * arg / 64
    localparam int unsigned RECIP_W  = 15;
    localparam int unsigned RPROD_W  = 32;
    localparam int unsigned DATA_W   = 24;

    // Hue and percentage limits
    localparam logic [HUE_W-1:0] HUE_TURN   = 9'd360;
    localparam logic [PCT_W-1:0] PCT_MAX    = 7'd100;
    localparam logic [OFF_W-1:0] SECTOR_DEG = 6'd60;

    // Every channel is floor(17 * v * arg / 40000) with arg = 6000 - s*x.
    // 40000 = 64 * 625: shift out 64, then divide by 625 through a reciprocal.
    localparam logic [ARG_W-1:0]    ARG_FULL  = 13'd6000;
    localparam int unsigned         DIV_SHIFT = 6;
    localparam logic [SCALED_W-1:0] DIV_ODD   = 18'd625;
    localparam logic [RECIP_W-1:0]  RECIP_K   = 15'd26843;   // floor(2^24 / 625)
    localparam int unsigned         RECIP_SH  = 24;

    // Hue sectors of 60 degrees each
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    // Load enables of the six pipeline stages
    typedef struct packed {
        logic st1;
        logic st2;
        logic st3;
        logic st4;
        logic st5;
        logic st6;
    } stage_en_t;

endpackage

`default_nettype wire

@@ hdl/hsv2rgb_prep.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_prep - input conditioning and term arguments
// Stage 1 clamps the inputs and splits hue into sector and offset; stage 2
// forms the arguments 6000 - s*x of the p, q and t terms.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_prep (
    input  wire logic                          aclk,
    input  wire hsv2rgb_pkg::stage_en_t        en,
    input  wire logic [hsv2rgb_pkg::HUE_W-1:0] hue_deg,
    input  wire logic [hsv2rgb_pkg::PCT_W-1:0] sat_pct,
    input  wire logic [hsv2rgb_pkg::PCT_W-1:0] val_pct,
    output hsv2rgb_pkg::sector_t               sector,
    output logic [hsv2rgb_pkg::PCT_W-1:0]      val,
    output logic [hsv2rgb_pkg::ARG_W-1:0]      arg_p,
    output logic [hsv2rgb_pkg::ARG_W-1:0]      arg_q,
    output logic [hsv2rgb_pkg::ARG_W-1:0]      arg_t
);
    import hsv2rgb_pkg::*;

    logic [HUE_W-1:0] hue_c;
    logic [HUE_W-1:0] base;
    sector_t          sector1_next;
    sector_t          sector1_reg;
    sector_t          sector2_reg;
    logic [OFF_W-1:0] off1_next;
    logic [OFF_W-1:0] off1_reg;
    logic [PCT_W-1:0] sat1_next;
    logic [PCT_W-1:0] sat1_reg;
    logic [PCT_W-1:0] val1_next;
    logic [PCT_W-1:0] val1_reg;
    logic [PCT_W-1:0] val2_reg;
    logic [ARG_W-1:0] sat_w;
    logic [ARG_W-1:0] arg_p_next;
    logic [ARG_W-1:0] arg_q_next;
    logic [ARG_W-1:0] arg_t_next;
    logic [ARG_W-1:0] arg_p_reg;
    logic [ARG_W-1:0] arg_q_reg;
    logic [ARG_W-1:0] arg_t_reg;

    // Fold out-of-range hue to zero, clamp percentages
    always_comb begin
        hue_c     = (hue_deg >= HUE_TURN) ? '0 : hue_deg;
        sat1_next = (sat_pct > PCT_MAX) ? PCT_MAX : sat_pct;
        val1_next = (val_pct > PCT_MAX) ? PCT_MAX : val_pct;
    end

    // Find the sector by comparing against its starting angle
    always_comb begin
        priority if (hue_c >= 9'd300) begin
            sector1_next = SEC_MAG_RED;
            base         = 9'd300;
        end else if (hue_c >= 9'd240) begin
            sector1_next = SEC_BLU_MAG;
            base         = 9'd240;
        end else if (hue_c >= 9'd180) begin
            sector1_next = SEC_CYN_BLU;
            base         = 9'd180;
        end else if (hue_c >= 9'd120) begin
            sector1_next = SEC_GRN_CYN;
            base         = 9'd120;
        end else if (hue_c >= 9'd60) begin
            sector1_next = SEC_YEL_GRN;
            base         = 9'd60;
        end else begin
            sector1_next = SEC_RED_YEL;
            base         = '0;
        end
        off1_next = OFF_W'(hue_c - base);
    end

    always_ff @(posedge aclk) begin
        if (en.st1) begin
            sector1_reg <= sector1_next;
            off1_reg    <= off1_next;
            sat1_reg    <= sat1_next;
            val1_reg    <= val1_next;
        end
    end

    // Term arguments: p uses s*60, q uses s*off, t uses s*(60-off)
    always_comb begin
        sat_w      = ARG_W'(sat1_reg);
        arg_p_next = ARG_FULL - sat_w * ARG_W'(SECTOR_DEG);
        arg_q_next = ARG_FULL - sat_w * ARG_W'(off1_reg);
        arg_t_next = ARG_FULL - sat_w * ARG_W'(SECTOR_DEG - off1_reg);
    end

    always_ff @(posedge aclk) begin
        if (en.st2) begin
            sector2_reg <= sector1_reg;
            val2_reg    <= val1_reg;
            arg_p_reg   <= arg_p_next;
            arg_q_reg   <= arg_q_next;
            arg_t_reg   <= arg_t_next;
        end
    end

    assign sector = sector2_reg;
    assign val    = val2_reg;
    assign arg_p  = arg_p_reg;
    assign arg_q  = arg_q_reg;
    assign arg_t  = arg_t_reg;

endmodule

`default_nettype wire

@@ hdl/hsv2rgb_lane.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_lane - one channel term, floor(17 * v * arg / 40000)
// Stage 3 multiplies v by arg, stage 4 scales by 17/64 and estimates the
// quotient by 625 through a reciprocal, stage 5 corrects it by at most one.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_lane (
    input  wire logic                          aclk,
    input  wire hsv2rgb_pkg::stage_en_t        en,
    input  wire logic [hsv2rgb_pkg::PCT_W-1:0] val,
    input  wire logic [hsv2rgb_pkg::ARG_W-1:0] arg,
    output logic [hsv2rgb_pkg::CH_W-1:0]       term
);
    import hsv2rgb_pkg::*;

    logic [PROD_W-1:0]   prod_next;
    logic [PROD_W-1:0]   prod_reg;
    logic [MUL17_W-1:0]  mul17;
    logic [SCALED_W-1:0] scaled;
    logic [RPROD_W-1:0]  rprod;
    logic [CH_W-1:0]     quot_next;
    logic [CH_W-1:0]     quot_reg;
    logic [SCALED_W-1:0] scaled_reg;
    logic [SCALED_W-1:0] back;
    logic [SCALED_W-1:0] rem;
    logic [CH_W-1:0]     term_next;
    logic [CH_W-1:0]     term_reg;

    // Stage 3: product of value and argument
    assign prod_next = PROD_W'(val) * PROD_W'(arg);

    always_ff @(posedge aclk) begin
        if (en.st3) begin
            prod_reg <= prod_next;
        end
    end

    // Stage 4: times 17, drop 64, estimate the quotient by 625
    always_comb begin
        mul17     = (MUL17_W'(prod_reg) << 4) + MUL17_W'(prod_reg);
        scaled    = mul17[MUL17_W-1:DIV_SHIFT];
        rprod     = RPROD_W'(scaled) * RPROD_W'(RECIP_K);
        quot_next = rprod[RECIP_SH +: CH_W];
    end

    always_ff @(posedge aclk) begin
        if (en.st4) begin
            quot_reg   <= quot_next;
            scaled_reg <= scaled;
        end
    end

    // Stage 5: the estimate is low by at most one
    always_comb begin
        back      = SCALED_W'(quot_reg) * DIV_ODD;
        rem       = scaled_reg - back;
        term_next = (rem >= DIV_ODD) ? quot_reg + CH_W'(1) : quot_reg;
    end

    always_ff @(posedge aclk) begin
        if (en.st5) begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

`default_nettype wire

@@ hdl/hsv_to_rgb_converter_core.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core - streaming HSV to 8-bit RGB pixel converter
// Six-stage pipeline: clamp and sector split, term arguments, multiply,
// reciprocal estimate, correction, sector routing into the output register.
//
//   channel  direction  beat fields (lowest bit first)
//   s_axis   in         hue_deg[8:0], sat_pct[15:9], val_pct[22:16]
//   m_axis   out        red[7:0], green[15:8], blue[23:16]
//
// One pixel per clock sustained while m_tready stays high; each pixel passes from
// input beat to output beat through the six register stages: two in the input
// conditioning, three in each term lane and the output register.
// Reset clears the stage valid bits only; the data path registers are not reset.
// A full stage holds while the one after it is full and stalled, so empty
// stages keep taking beats while a finished pixel waits on m_tready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hsv_to_rgb_converter_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // hue_deg[8:0], sat_pct[15:9], val_pct[22:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // red[7:0], green[15:8], blue[23:16]
);
    import hsv2rgb_pkg::*;

    stage_en_t        en;
    logic             vld1_reg;
    logic             vld2_reg;
    logic             vld3_reg;
    logic             vld4_reg;
    logic             vld5_reg;
    logic             vld6_reg;
    sector_t          sector2;
    sector_t          sector3_reg;
    sector_t          sector4_reg;
    sector_t          sector5_reg;
    logic [PCT_W-1:0] val2;
    logic [ARG_W-1:0] arg_p;
    logic [ARG_W-1:0] arg_q;
    logic [ARG_W-1:0] arg_t;
    logic [CH_W-1:0]  term_v;
    logic [CH_W-1:0]  term_p;
    logic [CH_W-1:0]  term_q;
    logic [CH_W-1:0]  term_t;
    logic [CH_W-1:0]  red_next;
    logic [CH_W-1:0]  green_next;
    logic [CH_W-1:0]  blue_next;
    logic [CH_W-1:0]  red_reg;
    logic [CH_W-1:0]  green_reg;
    logic [CH_W-1:0]  blue_reg;

    // A stage loads when it is empty or its successor loads
    always_comb begin
        en.st6 = !vld6_reg || m_tready;
        en.st5 = !vld5_reg || en.st6;
        en.st4 = !vld4_reg || en.st5;
        en.st3 = !vld3_reg || en.st4;
        en.st2 = !vld2_reg || en.st3;
        en.st1 = !vld1_reg || en.st2;
    end

    assign s_tready = en.st1;

    // Advance valid bits with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
        end else begin
            if (en.st1) vld1_reg <= s_tvalid;
            if (en.st2) vld2_reg <= vld1_reg;
            if (en.st3) vld3_reg <= vld2_reg;
            if (en.st4) vld4_reg <= vld3_reg;
            if (en.st5) vld5_reg <= vld4_reg;
            if (en.st6) vld6_reg <= vld5_reg;
        end
    end

    hsv2rgb_prep u_prep (
        .aclk    (aclk),
        .en      (en),
        .hue_deg (s_tdata[8:0]),
        .sat_pct (s_tdata[15:9]),
        .val_pct (s_tdata[22:16]),
        .sector  (sector2),
        .val     (val2),
        .arg_p   (arg_p),
        .arg_q   (arg_q),
        .arg_t   (arg_t)
    );

    // Four term lanes; the full value term has the whole argument
    hsv2rgb_lane u_lane_v (.aclk(aclk), .en(en), .val(val2), .arg(ARG_FULL), .term(term_v));
    hsv2rgb_lane u_lane_p (.aclk(aclk), .en(en), .val(val2), .arg(arg_p),    .term(term_p));
    hsv2rgb_lane u_lane_q (.aclk(aclk), .en(en), .val(val2), .arg(arg_q),    .term(term_q));
    hsv2rgb_lane u_lane_t (.aclk(aclk), .en(en), .val(val2), .arg(arg_t),    .term(term_t));

    // Carry the sector alongside the lanes
    always_ff @(posedge aclk) begin
        if (en.st3) sector3_reg <= sector2;
        if (en.st4) sector4_reg <= sector3_reg;
        if (en.st5) sector5_reg <= sector4_reg;
    end

    // Route terms to channels by sector
    always_comb begin
        unique case (sector5_reg)
            SEC_RED_YEL: begin
                red_next = term_v; green_next = term_t; blue_next = term_p;
            end
            SEC_YEL_GRN: begin
                red_next = term_q; green_next = term_v; blue_next = term_p;
            end
            SEC_GRN_CYN: begin
                red_next = term_p; green_next = term_v; blue_next = term_t;
            end
            SEC_CYN_BLU: begin
                red_next = term_p; green_next = term_q; blue_next = term_v;
            end
            SEC_BLU_MAG: begin
                red_next = term_t; green_next = term_p; blue_next = term_v;
            end
            default: begin
                red_next = term_v; green_next = term_p; blue_next = term_q;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en.st6) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_tvalid = vld6_reg;
    assign m_tdata  = {blue_reg, green_reg, red_reg};

    // Input stops only when every stage is full
    `HSV_ASSERT_NOW(a_full_when_blocked, aclk, aresetn, !s_tready,
        vld1_reg && vld2_reg && vld3_reg && vld4_reg && vld5_reg && vld6_reg,
        "input blocked with an empty stage")
    // An accepted beat lands in stage one
    `HSV_ASSERT_NEXT(a_accept_lands, aclk, aresetn, s_tvalid && s_tready, vld1_reg,
        "accepted beat missing from stage one")
    // A stalled output keeps the last lane stage occupied
    `HSV_ASSERT_NEXT(a_stall_holds, aclk, aresetn, vld6_reg && !m_tready && vld5_reg,
        vld5_reg && $stable(sector5_reg), "stage five lost its pixel under stall")

endmodule

`default_nettype wire

@@ dv/hsv_to_rgb_converter_checker.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_checker - pixel predictor and output comparator
// Watches both stream channels of the HSV to RGB core. Each input beat is
// converted to the RGB pixel it should produce, and each output beat is
// compared channel by channel with the oldest pixel still pending.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_checker
    import hsv2rgb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // hue_deg[8:0], sat_pct[15:9], val_pct[22:16]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // red[7:0], green[15:8], blue[23:16]
    output int          mismatch_count,
    output int          pixels_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FULL_TURN  = 360;
    localparam int unsigned SECTOR_SPAN = 60;
    localparam int unsigned PCT_FULL   = 100;
    localparam int unsigned CH_FULL    = 255;

    // Output beat layout, red in the lowest byte
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_pixel_t;

    rgb_pixel_t rgb_q[$];
    int         errors  = 0;
    int         waiting = 0;

    assign mismatch_count = errors;
    assign pixels_pending = waiting;

    // Exact rational conversion, truncated once at the end
    function automatic rgb_pixel_t hsv_to_rgb(logic [8:0] hue, logic [6:0] sat,
                                              logic [6:0] val);
        int unsigned h, s, v, off, level, p, q, t, span_pct;
        sector_t     sec;
        rgb_pixel_t  px;
        h = hue;
        s = sat;
        v = val;
        // Wrap a hue past the full turn to zero, clamp the percentages
        if (h >= FULL_TURN) h = 0;
        if (s > PCT_FULL) s = PCT_FULL;
        if (v > PCT_FULL) v = PCT_FULL;
        span_pct = PCT_FULL * SECTOR_SPAN;
        level    = (CH_FULL * v) / PCT_FULL;
        if (s == 0) begin
            px.red   = level[7:0];
            px.green = level[7:0];
            px.blue  = level[7:0];
        end else begin
            off = h % SECTOR_SPAN;
            sec = sector_t'(h / SECTOR_SPAN);
            p = (CH_FULL * v * (PCT_FULL - s)) / (PCT_FULL * PCT_FULL);
            q = (CH_FULL * v * (span_pct - s * off)) / (PCT_FULL * span_pct);
            t = (CH_FULL * v * (span_pct - s * (SECTOR_SPAN - off))) / (PCT_FULL * span_pct);
            case (sec)
                SEC_RED_YEL: begin px.red = level[7:0]; px.green = t[7:0];     px.blue = p[7:0]; end
                SEC_YEL_GRN: begin px.red = q[7:0];     px.green = level[7:0]; px.blue = p[7:0]; end
                SEC_GRN_CYN: begin px.red = p[7:0];     px.green = level[7:0]; px.blue = t[7:0]; end
                SEC_CYN_BLU: begin px.red = p[7:0];     px.green = q[7:0];     px.blue = level[7:0]; end
                SEC_BLU_MAG: begin px.red = t[7:0];     px.green = p[7:0];     px.blue = level[7:0]; end
                default: begin     px.red = level[7:0]; px.green = p[7:0];     px.blue = q[7:0]; end
            endcase
        end
        return px;
    endfunction

    // Retire output beats first, then queue the pixel of an input beat
    always @(posedge aclk) begin : watch_beats
        rgb_pixel_t seen;
        rgb_pixel_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                seen = m_tdata;
                if (rgb_q.size() == 0) begin
                    $error("output beat %h arrived with no pixel pending", m_tdata);
                    errors++;
                end else begin
                    want = rgb_q.pop_front();
                    if (seen.red !== want.red) begin
                        $error("red: expected %0d, got %0d", want.red, seen.red);
                        errors++;
                    end
                    if (seen.green !== want.green) begin
                        $error("green: expected %0d, got %0d", want.green, seen.green);
                        errors++;
                    end
                    if (seen.blue !== want.blue) begin
                        $error("blue: expected %0d, got %0d", want.blue, seen.blue);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                rgb_q.push_back(hsv_to_rgb(s_tdata[8:0], s_tdata[15:9], s_tdata[22:16]));
            end
            waiting = rgb_q.size();
        end
    end

endmodule

@@ dv/hsv_to_rgb_converter_core_test.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core_test - stream test of the HSV to RGB core
// Sends directed corner pixels, then bursts of random pixels with random gaps,
// while the output side stalls on its own pattern with long hold-offs that
// back the pipeline up. The checker beside the core predicts every pixel.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam time CLK_PERIOD   = 12ns;
    localparam int  RESET_CYCLES = 8;
    localparam int  RANDOM_PIXELS = 1600;
    localparam int  PIPE_DEPTH   = 6;
    localparam int  HOLD_LEN     = 80;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // hue_deg[8:0], sat_pct[15:9], val_pct[22:16]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // red[7:0], green[15:8], blue[23:16]

    int          mismatch_count;
    int          pixels_pending;

    hsv_to_rgb_converter_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    hsv_to_rgb_converter_checker pixel_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pixels_pending (pixels_pending)
    );

    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Offer one pixel and hold it until the core takes the beat
    task automatic send_pixel(input logic [8:0] hue, input logic [6:0] sat,
                              input logic [6:0] val);
        logic ready_seen;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, val, sat, hue};
        do begin
            @(negedge aclk);
            ready_seen = s_tready;
            @(posedge aclk);
        end while (!ready_seen);
    endtask

    // Mostly in-range pixels, with a share across the whole field widths
    task automatic send_random_pixel();
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] val;
        hue = ($urandom_range(0, 9) < 7) ? 9'($urandom_range(0, 359))
                                         : 9'($urandom_range(0, 511));
        case ($urandom_range(0, 9))
            0:       sat = 7'd0;
            1:       sat = 7'($urandom_range(0, 127));
            default: sat = 7'($urandom_range(1, 100));
        endcase
        val = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                          : 7'($urandom_range(0, 100));
        send_pixel(hue, sat, val);
    endtask

    // Stimulus: reset, directed corners, random bursts, drain
    initial begin
        int sent;
        int burst;
        int gap;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sector edges at full saturation and value
        send_pixel(9'd0,   7'd100, 7'd100);
        send_pixel(9'd59,  7'd100, 7'd100);
        send_pixel(9'd60,  7'd100, 7'd100);
        send_pixel(9'd119, 7'd100, 7'd100);
        send_pixel(9'd120, 7'd100, 7'd100);
        send_pixel(9'd179, 7'd100, 7'd100);
        send_pixel(9'd180, 7'd100, 7'd100);
        send_pixel(9'd239, 7'd100, 7'd100);
        send_pixel(9'd240, 7'd100, 7'd100);
        send_pixel(9'd299, 7'd100, 7'd100);
        send_pixel(9'd300, 7'd100, 7'd100);
        send_pixel(9'd359, 7'd100, 7'd100);
        // Hue past the full turn wraps to zero
        send_pixel(9'd360, 7'd100, 7'd100);
        send_pixel(9'd511, 7'd127, 7'd127);
        // Gray when saturation is zero
        send_pixel(9'd30,  7'd0,   7'd100);
        send_pixel(9'd200, 7'd0,   7'd127);
        send_pixel(9'd0,   7'd0,   7'd0);
        // Clamped saturation and value, smallest non-zero terms
        send_pixel(9'd45,  7'd101, 7'd50);
        send_pixel(9'd270, 7'd127, 7'd101);
        send_pixel(9'd90,  7'd50,  7'd0);
        send_pixel(9'd150, 7'd1,   7'd1);
        send_pixel(9'd330, 7'd75,  7'd63);

        // Random bursts, some of them followed by no gap at all
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            burst = $urandom_range(1, 32);
            for (int i = 0; i < burst && sent < RANDOM_PIXELS; i++) begin
                send_random_pixel();
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;

        // Drain every pending pixel, then let the pipeline settle
        do @(negedge aclk); while (pixels_pending != 0);
        repeat (2 * PIPE_DEPTH + 4) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Output side: switch between stall patterns at random, with long hold-offs
    initial begin
        int cycle_cnt;
        int hold_left;
        int mode;
        cycle_cnt = 0;
        hold_left = 0;
        mode      = 0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            cycle_cnt++;
            if (cycle_cnt % 64 == 0) mode = $urandom_range(0, 3);
            if (cycle_cnt == 40 || cycle_cnt == 900 || cycle_cnt == 2500) begin
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 9) < 7);
                    2:       m_tready <= (cycle_cnt % 3 == 0);
                    default: m_tready <= ($urandom_range(0, 1) == 1);
                endcase
            end
        end
    end

    // Hard stop should the core hang
    initial begin
        #(CLK_PERIOD * 200_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
